// File: rtl/core/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

   localparam int TAG_W = 16;
   localparam int PRI_W = 2;
   localparam int OCC_W = 5;

   localparam logic [TAG_W-1:0] TAG_FIRST = 16'd1;
   localparam logic [TAG_W-1:0] TAG_LAST  = 16'hFFFF;
   localparam logic [PRI_W-1:0] PRI_NONE   = 2'd0;
   localparam logic [PRI_W-1:0] PRI_URGENT = 2'd1;

   typedef enum logic [1:0] {
      ACT_INSERT          = 2'd0,
      ACT_REMOVE          = 2'd1,
      ACT_SERVE_HEAD      = 2'd2,
      ACT_SERVE_NONURGENT = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_FULL     = 2'd1,
      STS_NONE     = 2'd2,
      STS_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic step;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;
   } sts_type;

endpackage

// File: rtl/core/spq_req_if.sv
`timescale 1ns / 1ps

interface spq_req_if;
   import spq_pkg::*;

   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic [PRI_W-1:0]   new_priority;
   logic [TAG_W-1:0]   target_tag;

   modport source (output valid, output action, output new_priority, output target_tag,
                   input ready);
   modport sink (input valid, input action, input new_priority, input target_tag,
                 output ready);
endinterface

// File: rtl/core/spq_rsp_if.sv
`timescale 1ns / 1ps

interface spq_rsp_if;
   import spq_pkg::*;

   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [TAG_W-1:0]   result_tag;
   logic [PRI_W-1:0]   result_priority;
   logic [OCC_W-1:0]   occupancy;

   modport source (output valid, output status, output result_tag, output result_priority,
                   output occupancy, input ready);
   modport sink (input valid, input status, input result_tag, input result_priority,
                 input occupancy, output ready);
endinterface

// File: rtl/core/spq_ctrl.sv
`timescale 1ns / 1ps

module spq_ctrl
   import spq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type cmd,
   input  sts_type sts
);

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      in_ready     = 1'b0;
      out_valid_in = out_valid_ff && !out_ready;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.scan_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_FINISH: begin
            // The result register may still hold the previous transaction.
            if (!out_valid_ff || out_ready) begin
               cmd.emit     = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign out_valid = out_valid_ff;

endmodule

// File: rtl/core/spq_dpath.sv
`timescale 1ns / 1ps

module spq_dpath
   import spq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
)
(
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output sts_type          sts,
   input  logic [1:0]       in_action,
   input  logic [PRI_W-1:0] in_priority,
   input  logic [TAG_W-1:0] in_tag,
   output logic [1:0]       out_status,
   output logic [TAG_W-1:0] out_tag,
   output logic [PRI_W-1:0] out_priority,
   output logic [OCC_W-1:0] out_occupancy
);

   localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

   // Slot chain: slot 0 is the head. Entries are packed at the front.
   logic [TAG_W-1:0] slot_tag_ff [QUEUE_DEPTH];
   logic [PRI_W-1:0] slot_pri_ff [QUEUE_DEPTH];

   logic [CW-1:0]    count_ff;
   logic [TAG_W-1:0] next_tag_ff;

   action_type       act_ff;
   logic [PRI_W-1:0] pri_ff;
   logic [TAG_W-1:0] target_ff;
   logic [CW-1:0]    total_ff;
   logic [CW-1:0]    popped_ff;
   logic             inserted_ff;
   logic             found_ff;
   logic             full_ff;
   logic [TAG_W-1:0] res_tag_ff;
   logic [PRI_W-1:0] res_pri_ff;

   logic [1:0]       status_ff;
   logic [TAG_W-1:0] rtag_ff;
   logic [PRI_W-1:0] rpri_ff;
   logic [OCC_W-1:0] occ_ff;

   logic [TAG_W-1:0] head_tag;
   logic [PRI_W-1:0] head_pri;
   logic             all_popped;
   logic             do_put;
   logic             do_drop;
   logic             hit;
   logic [CW-1:0]    count_m1;
   logic [IW-1:0]    put_idx;
   logic [IW-1:0]    tail_idx;
   status_type       status_c;
   action_type       in_act;

   assign in_act     = action_type'(in_action);
   assign head_tag   = slot_tag_ff[0];
   assign head_pri   = slot_pri_ff[0];
   assign all_popped = (popped_ff == total_ff);
   assign count_m1   = count_ff - 1'b1;
   assign put_idx    = count_ff[IW-1:0];
   assign tail_idx   = count_m1[IW-1:0];

   // Each step takes the head; it is either dropped or rotated to the tail.
   // An insert instead places the new entry at the tail, ahead of the first
   // entry with a larger priority number, so the original order is restored
   // once every entry has gone around.
   always_comb begin
      case (act_ff)
         ACT_REMOVE:          hit = (head_tag == target_ff);
         ACT_SERVE_HEAD:      hit = 1'b1;
         ACT_SERVE_NONURGENT: hit = (head_pri != PRI_URGENT);
         default:             hit = 1'b0;
      endcase
   end

   assign do_put  = (act_ff == ACT_INSERT) && !inserted_ff &&
                    (all_popped || (head_pri > pri_ff));
   assign do_drop = (act_ff != ACT_INSERT) && !found_ff && !all_popped && hit;

   assign sts.scan_done = full_ff ||
                          (all_popped && (inserted_ff || (act_ff != ACT_INSERT)));

   always_comb begin
      if (full_ff) begin
         status_c = STS_FULL;
      end else if (act_ff == ACT_INSERT || found_ff) begin
         status_c = STS_OK;
      end else if (act_ff == ACT_REMOVE) begin
         status_c = STS_NOT_FOUND;
      end else begin
         status_c = STS_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         if (do_put) begin
            slot_tag_ff[put_idx] <= next_tag_ff;
            slot_pri_ff[put_idx] <= pri_ff;
         end else begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
               if (do_drop || i != int'(tail_idx)) begin
                  slot_tag_ff[i] <= slot_tag_ff[i+1];
                  slot_pri_ff[i] <= slot_pri_ff[i+1];
               end
            end
            if (!do_drop) begin
               slot_tag_ff[tail_idx] <= head_tag;
               slot_pri_ff[tail_idx] <= head_pri;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         next_tag_ff <= TAG_FIRST;
         inserted_ff <= 1'b0;
         found_ff    <= 1'b0;
         full_ff     <= 1'b0;
         popped_ff   <= '0;
         total_ff    <= '0;
         act_ff      <= ACT_INSERT;
      end else if (cmd.load) begin
         act_ff      <= in_act;
         total_ff    <= count_ff;
         popped_ff   <= '0;
         inserted_ff <= 1'b0;
         found_ff    <= 1'b0;
         full_ff     <= (in_act == ACT_INSERT) && (count_ff == DEPTH_C);
      end else if (cmd.step) begin
         if (do_put) begin
            count_ff    <= count_ff + 1'b1;
            inserted_ff <= 1'b1;
            next_tag_ff <= (next_tag_ff == TAG_LAST) ? TAG_FIRST : next_tag_ff + 1'b1;
         end else begin
            popped_ff <= popped_ff + 1'b1;
            if (do_drop) begin
               count_ff <= count_m1;
               found_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pri_ff     <= (in_priority == PRI_NONE) ? PRI_URGENT : in_priority;
         target_ff  <= in_tag;
         res_tag_ff <= '0;
         res_pri_ff <= PRI_NONE;
      end else if (cmd.step) begin
         if (do_put) begin
            res_tag_ff <= next_tag_ff;
            res_pri_ff <= pri_ff;
         end else if (do_drop) begin
            res_tag_ff <= head_tag;
            res_pri_ff <= head_pri;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         status_ff <= status_c;
         rtag_ff   <= res_tag_ff;
         rpri_ff   <= res_pri_ff;
         occ_ff    <= OCC_W'(count_ff);
      end
   end

   assign out_status    = status_ff;
   assign out_tag       = rtag_ff;
   assign out_priority  = rpri_ff;
   assign out_occupancy = occ_ff;

endmodule

// File: rtl/core/stable_priority_queue_with_removal_core.sv
`timescale 1ns / 1ps

// Stable priority queue of up to QUEUE_DEPTH entries, ordered by priority
// (1 most urgent) and first in, first out within a priority. Every request
// transaction gives exactly one response transaction. The entries sit in a
// chain of slots that is walked by rotating it one entry per cycle past the
// head, so the time from one acceptance to the next grows with the occupancy
// at the start; an insert into a full queue skips the walk. A new request is
// taken while the previous response still waits in the output register.

module stable_priority_queue_with_removal_core
   import spq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
)
(
   input  logic      clock,
   input  logic      reset,
   spq_req_if.sink   req,
   spq_rsp_if.source rsp
);

   cmd_type cmd;
   sts_type sts;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   spq_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .in_action     (req.action),
      .in_priority   (req.new_priority),
      .in_tag        (req.target_tag),
      .out_status    (rsp.status),
      .out_tag       (rsp.result_tag),
      .out_priority  (rsp.result_priority),
      .out_occupancy (rsp.occupancy)
   );

endmodule
